// ===== rtl/e2c_pkg.sv =====
// Shared constants and types for the epoch-seconds to calendar converter.
// Used by every module of the block; depends on nothing.

package e2c_pkg;

    // Field widths
    localparam int SECS_W   = 32;
    localparam int UPTIME_W = 48;
    localparam int DAYS_W   = 16;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    // Time base used without a clock, 2026-01-01 00:00:00 UTC
    localparam logic [SECS_W-1:0] BOOT_EPOCH_SECS = 32'd1767225600;

    // Milliseconds to seconds: divide by 1000 one 16-bit digit at a time, two stages
    // per digit: quotient digit of {remainder, digit}, then the new remainder.
    // digit quotient = ((v >> 3) * MS_RECIP) >> MS_SHIFT, exact for 23-bit operands
    localparam int MS_DIV    = 1000;
    localparam int MS_REM_W  = 10;
    localparam int MS_DIG    = 16;
    localparam int MS_DVD_W  = MS_REM_W + MS_DIG;
    localparam int MS_PRE    = 3;
    localparam int MS_RECIP  = 8589935;
    localparam int MS_SHIFT  = 30;
    localparam int MS_PROD_W = 47;
    localparam int MS_STG    = 2 * (UPTIME_W / MS_DIG);

    // Seconds split
    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int REM_W        = 17;  // seconds of day
    localparam int RMIN_W       = 12;  // seconds of hour
    // days = ((secs >> 7) * DAY_RECIP) >> DAY_SHIFT, exact for 25-bit operands
    localparam int DAY_PRE   = 7;
    localparam int DAY_RECIP = 50903317;
    localparam int DAY_SHIFT = 35;
    // hour = ((rem >> 4) * HR_RECIP) >> HR_SHIFT
    localparam int HR_PRE   = 4;
    localparam int HR_RECIP = 9321;
    localparam int HR_SHIFT = 21;
    // minute = ((r >> 2) * MN_RECIP) >> MN_SHIFT
    localparam int MN_PRE   = 2;
    localparam int MN_RECIP = 1093;
    localparam int MN_SHIFT = 14;

    // Civil date from days
    localparam int DAYS_TO_MARCH_ZERO = 719468;
    localparam int DAYS_PER_ERA       = 146097;
    localparam int YEARS_PER_ERA      = 400;
    localparam int DAYS_PER_CENT      = 36524;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int DOE_W              = 18;
    localparam int YOE_W              = 9;
    localparam int DOY_W              = 9;
    localparam int MP_W               = 4;
    // A 16-bit day count lands in era 4 or era 5 only
    localparam int ERA5_SPLIT  = 5 * DAYS_PER_ERA - DAYS_TO_MARCH_ZERO;
    localparam int ERA4_OFFSET = DAYS_TO_MARCH_ZERO - 4 * DAYS_PER_ERA;
    localparam int ERA4_YEAR   = 4 * YEARS_PER_ERA;
    localparam int ERA5_YEAR   = 5 * YEARS_PER_ERA;
    // doe / 1460 = ((doe >> 2) * Y4_RECIP) >> Y4_SHIFT
    localparam int Y4_RECIP = 91930;
    localparam int Y4_SHIFT = 25;
    // yoe = (t * YR_RECIP) >> YR_SHIFT
    localparam int YR_RECIP = 367720;
    localparam int YR_SHIFT = 27;

    // First day of each month counted from March, floor((153 * mp + 2) / 5)
    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_hms;

endpackage

// ===== rtl/e2c_msdiv.sv =====
// Uptime-to-seconds front end: pipelined divider by 1000 (reciprocal multiply per
// 16-bit digit) and the clock / fallback select. Depends on e2c_pkg.

module e2c_msdiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clock_present,
    input  logic                        i_vld,
    input  logic [e2c_pkg::SECS_W-1:0]   i_rtc_seconds,
    input  logic [e2c_pkg::UPTIME_W-1:0] i_uptime_ms,
    output logic                        o_rdy,
    input  logic                        i_nxt_rdy,
    output logic                        o_vld,
    output logic [e2c_pkg::SECS_W-1:0]   o_secs
);

    typedef struct packed {
        logic [e2c_pkg::UPTIME_W-1:0] num;
        logic [e2c_pkg::MS_REM_W-1:0] rem;
        logic [e2c_pkg::MS_DIG-1:0]   qd;
        logic [e2c_pkg::SECS_W-1:0]   quo;
        logic [e2c_pkg::SECS_W-1:0]   rtc;
    } t_ms;

    t_ms                           r_ms   [e2c_pkg::MS_STG];
    t_ms                           n_ms   [e2c_pkg::MS_STG];
    t_ms                           stg_in [e2c_pkg::MS_STG];
    logic [e2c_pkg::MS_DVD_W-1:0]  dvd    [e2c_pkg::MS_STG];
    logic [e2c_pkg::MS_PROD_W-1:0] prod   [e2c_pkg::MS_STG];
    logic [e2c_pkg::MS_DVD_W-1:0]  dif    [e2c_pkg::MS_STG];
    logic [e2c_pkg::MS_STG-1:0]    r_v;
    logic [e2c_pkg::MS_STG-1:0]    v_in;
    logic [e2c_pkg::MS_STG:0]      adv;
    logic                          r_sv;
    logic [e2c_pkg::SECS_W-1:0]    r_secs;
    logic [e2c_pkg::SECS_W-1:0]    n_secs;

    always_comb begin
        // a stage moves when it is empty or the one after it moves
        adv[e2c_pkg::MS_STG] = !r_sv || i_nxt_rdy;
        for (int s = e2c_pkg::MS_STG - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end

        stg_in[0].num = i_uptime_ms;
        stg_in[0].rem = '0;
        stg_in[0].qd  = '0;
        stg_in[0].quo = '0;
        stg_in[0].rtc = i_rtc_seconds;
        v_in[0]       = i_vld;
        for (int s = 1; s < e2c_pkg::MS_STG; s++) begin
            stg_in[s] = r_ms[s-1];
            v_in[s]   = r_v[s-1];
        end

        for (int s = 0; s < e2c_pkg::MS_STG; s++) begin
            dvd[s]  = {stg_in[s].rem, stg_in[s].num[e2c_pkg::UPTIME_W-1 -: e2c_pkg::MS_DIG]};
            prod[s] = '0;
            dif[s]  = '0;
            n_ms[s] = stg_in[s];
            if (s[0] == 1'b0) begin
                // quotient digit of {remainder, next 16 uptime bits}
                prod[s] = e2c_pkg::MS_PROD_W'(dvd[s][e2c_pkg::MS_DVD_W-1:e2c_pkg::MS_PRE])
                          * e2c_pkg::MS_PROD_W'(e2c_pkg::MS_RECIP);
                n_ms[s].qd = prod[s][e2c_pkg::MS_SHIFT +: e2c_pkg::MS_DIG];
            end else begin
                // keep the remainder, append the digit, advance to the next 16 bits
                dif[s] = dvd[s] - e2c_pkg::MS_DVD_W'(stg_in[s].qd)
                         * e2c_pkg::MS_DVD_W'(e2c_pkg::MS_DIV);
                n_ms[s].rem = dif[s][e2c_pkg::MS_REM_W-1:0];
                // keep the low quotient bits only; the top ones fall off
                n_ms[s].quo = {stg_in[s].quo[e2c_pkg::SECS_W-e2c_pkg::MS_DIG-1:0],
                               stg_in[s].qd};
                n_ms[s].num = stg_in[s].num << e2c_pkg::MS_DIG;
            end
        end

        if (i_clock_present) begin
            n_secs = r_ms[e2c_pkg::MS_STG-1].rtc;
        end else begin
            n_secs = r_ms[e2c_pkg::MS_STG-1].quo + e2c_pkg::BOOT_EPOCH_SECS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_sv <= 1'b0;
        end else begin
            for (int s = 0; s < e2c_pkg::MS_STG; s++) begin
                if (adv[s]) begin
                    r_v[s] <= v_in[s];
                end
            end
            if (adv[e2c_pkg::MS_STG]) begin
                r_sv <= r_v[e2c_pkg::MS_STG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < e2c_pkg::MS_STG; s++) begin
            if (adv[s]) begin
                r_ms[s] <= n_ms[s];
            end
        end
        if (adv[e2c_pkg::MS_STG]) begin
            r_secs <= n_secs;
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_sv;
    assign o_secs = r_secs;

endmodule

// ===== rtl/e2c_split.sv =====
// Seconds split: day count and hour / minute / second of day, one constant
// multiply per stage. Depends on e2c_pkg.

module e2c_split (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [e2c_pkg::SECS_W-1:0] i_secs,
    output logic                      o_rdy,
    input  logic                      i_nxt_rdy,
    output logic                      o_vld,
    output logic [e2c_pkg::DAYS_W-1:0] o_days,
    output e2c_pkg::t_hms             o_hms
);

    localparam int SP_STG = 6;

    typedef struct packed {
        logic [e2c_pkg::SECS_W-1:0] secs;
        logic [e2c_pkg::DAYS_W-1:0] days;
        logic [e2c_pkg::REM_W-1:0]  rem;
        logic [e2c_pkg::RMIN_W-1:0] rmin;
        e2c_pkg::t_hms              hms;
    } t_sp;

    t_sp                        r_s [SP_STG];
    t_sp                        n_s [SP_STG];
    logic [SP_STG-1:0]          r_v;
    logic [SP_STG-1:0]          v_in;
    logic [SP_STG:0]            adv;
    logic [50:0]                day_prod;
    logic [e2c_pkg::SECS_W-1:0]  day_rem;
    logic [26:0]                hr_prod;
    logic [e2c_pkg::REM_W-1:0]   hr_rem;
    logic [20:0]                mn_prod;
    logic [e2c_pkg::RMIN_W-1:0]  mn_rem;

    always_comb begin
        adv[SP_STG] = i_nxt_rdy;
        for (int s = SP_STG - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end

        v_in[0] = i_vld;
        n_s[0]  = '0;
        for (int s = 1; s < SP_STG; s++) begin
            n_s[s]  = r_s[s-1];
            v_in[s] = r_v[s-1];
        end

        // day count
        day_prod = 51'(i_secs[e2c_pkg::SECS_W-1:e2c_pkg::DAY_PRE]) * 51'(e2c_pkg::DAY_RECIP);
        n_s[0].secs = i_secs;
        n_s[0].days = day_prod[e2c_pkg::DAY_SHIFT +: e2c_pkg::DAYS_W];

        // seconds of day
        day_rem = r_s[0].secs - 32'(r_s[0].days) * 32'(e2c_pkg::SEC_PER_DAY);
        n_s[1].rem = day_rem[e2c_pkg::REM_W-1:0];

        // hour
        hr_prod = 27'(r_s[1].rem[e2c_pkg::REM_W-1:e2c_pkg::HR_PRE]) * 27'(e2c_pkg::HR_RECIP);
        n_s[2].hms.hour = hr_prod[e2c_pkg::HR_SHIFT +: e2c_pkg::HOUR_W];

        // seconds of hour
        hr_rem = r_s[2].rem - e2c_pkg::REM_W'(r_s[2].hms.hour)
                 * e2c_pkg::REM_W'(e2c_pkg::SEC_PER_HOUR);
        n_s[3].rmin = hr_rem[e2c_pkg::RMIN_W-1:0];

        // minute
        mn_prod = 21'(r_s[3].rmin[e2c_pkg::RMIN_W-1:e2c_pkg::MN_PRE]) * 21'(e2c_pkg::MN_RECIP);
        n_s[4].hms.minute = mn_prod[e2c_pkg::MN_SHIFT +: e2c_pkg::MIN_W];

        // second
        mn_rem = r_s[4].rmin - e2c_pkg::RMIN_W'(r_s[4].hms.minute)
                 * e2c_pkg::RMIN_W'(e2c_pkg::SEC_PER_MIN);
        n_s[5].hms.second = mn_rem[e2c_pkg::SEC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < SP_STG; s++) begin
                if (adv[s]) begin
                    r_v[s] <= v_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SP_STG; s++) begin
            if (adv[s]) begin
                r_s[s] <= n_s[s];
            end
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_v[SP_STG-1];
    assign o_days = r_s[SP_STG-1].days;
    assign o_hms  = r_s[SP_STG-1].hms;

endmodule

// ===== rtl/e2c_civil.sv =====
// Civil date from a day count (400-year era method, years start in March),
// carrying the time of day alongside. Depends on e2c_pkg.

module e2c_civil (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [e2c_pkg::DAYS_W-1:0]  i_days,
    input  e2c_pkg::t_hms              i_hms,
    output logic                       o_rdy,
    input  logic                       i_nxt_rdy,
    output logic                       o_vld,
    output logic [e2c_pkg::YEAR_W-1:0]  o_year,
    output logic [e2c_pkg::MONTH_W-1:0] o_month,
    output logic [e2c_pkg::DAY_W-1:0]   o_day,
    output e2c_pkg::t_hms              o_hms
);

    localparam int CV_STG = 8;

    typedef struct packed {
        logic                         era5;
        logic [e2c_pkg::DOE_W-1:0]    doe;
        logic [6:0]                   q1;
        logic [2:0]                   q2;
        logic                         q3;
        logic [e2c_pkg::DOE_W-1:0]    t;
        logic [e2c_pkg::YOE_W-1:0]    yoe;
        logic [e2c_pkg::DOE_W-1:0]    a;
        logic [e2c_pkg::DOY_W-1:0]    doy;
        logic [e2c_pkg::MP_W-1:0]     mp;
        logic [e2c_pkg::YEAR_W-1:0]   year;
        logic [e2c_pkg::MONTH_W-1:0]  month;
        logic [e2c_pkg::DAY_W-1:0]    day;
        e2c_pkg::t_hms                hms;
    } t_cv;

    t_cv                        r_c [CV_STG];
    t_cv                        n_c [CV_STG];
    logic [CV_STG-1:0]          r_v;
    logic [CV_STG-1:0]          v_in;
    logic [CV_STG:0]            adv;
    logic [32:0]                q1_prod;
    logic [36:0]                yoe_prod;
    logic [1:0]                 cent;
    logic [e2c_pkg::DOE_W-1:0]   doy_full;
    logic [e2c_pkg::DOY_W-1:0]   day_full;
    logic [e2c_pkg::YEAR_W-1:0]  year_base;

    always_comb begin
        adv[CV_STG] = i_nxt_rdy;
        for (int s = CV_STG - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end

        v_in[0] = i_vld;
        n_c[0]  = '0;
        for (int s = 1; s < CV_STG; s++) begin
            n_c[s]  = r_c[s-1];
            v_in[s] = r_v[s-1];
        end

        // era and day of era
        n_c[0].hms  = i_hms;
        n_c[0].era5 = i_days >= e2c_pkg::DAYS_W'(e2c_pkg::ERA5_SPLIT);
        if (n_c[0].era5) begin
            n_c[0].doe = e2c_pkg::DOE_W'(i_days) - e2c_pkg::DOE_W'(e2c_pkg::ERA5_SPLIT);
        end else begin
            n_c[0].doe = e2c_pkg::DOE_W'(i_days) + e2c_pkg::DOE_W'(e2c_pkg::ERA4_OFFSET);
        end

        // leap corrections: doe / 1460, doe / 36524, doe / 146096
        q1_prod = 33'(r_c[0].doe[e2c_pkg::DOE_W-1:2]) * 33'(e2c_pkg::Y4_RECIP);
        n_c[1].q1 = q1_prod[e2c_pkg::Y4_SHIFT +: 7];
        n_c[1].q2 = '0;
        for (int k = 1; k <= 4; k++) begin
            n_c[1].q2 = n_c[1].q2
                + 3'(r_c[0].doe >= e2c_pkg::DOE_W'(k * e2c_pkg::DAYS_PER_CENT));
        end
        n_c[1].q3 = r_c[0].doe == e2c_pkg::DOE_W'(e2c_pkg::DAYS_PER_ERA - 1);

        n_c[2].t = r_c[1].doe - e2c_pkg::DOE_W'(r_c[1].q1) + e2c_pkg::DOE_W'(r_c[1].q2)
                   - e2c_pkg::DOE_W'(r_c[1].q3);

        // year of era
        yoe_prod = 37'(r_c[2].t) * 37'(e2c_pkg::YR_RECIP);
        n_c[3].yoe = yoe_prod[e2c_pkg::YR_SHIFT +: e2c_pkg::YOE_W];

        // days before this year within the era
        cent = '0;
        for (int k = 1; k <= 3; k++) begin
            cent = cent + 2'(r_c[3].yoe >= e2c_pkg::YOE_W'(k * 100));
        end
        n_c[4].a = e2c_pkg::DOE_W'(r_c[3].yoe) * e2c_pkg::DOE_W'(e2c_pkg::DAYS_PER_YEAR)
                   + e2c_pkg::DOE_W'(r_c[3].yoe[e2c_pkg::YOE_W-1:2])
                   - e2c_pkg::DOE_W'(cent);

        doy_full = r_c[4].doe - r_c[4].a;
        n_c[5].doy = doy_full[e2c_pkg::DOY_W-1:0];

        // month counted from March
        n_c[6].mp = '0;
        for (int k = 1; k < 12; k++) begin
            n_c[6].mp = n_c[6].mp + e2c_pkg::MP_W'(r_c[5].doy >= e2c_pkg::MONTH_START[k]);
        end

        // January and February belong to the next year
        day_full = r_c[6].doy - e2c_pkg::MONTH_START[r_c[6].mp] + 9'd1;
        n_c[7].day = day_full[e2c_pkg::DAY_W-1:0];
        if (r_c[6].mp < 4'd10) begin
            n_c[7].month = r_c[6].mp + 4'd3;
        end else begin
            n_c[7].month = r_c[6].mp - 4'd9;
        end
        if (r_c[6].era5) begin
            year_base = e2c_pkg::YEAR_W'(e2c_pkg::ERA5_YEAR);
        end else begin
            year_base = e2c_pkg::YEAR_W'(e2c_pkg::ERA4_YEAR);
        end
        n_c[7].year = year_base + e2c_pkg::YEAR_W'(r_c[6].yoe)
                      + e2c_pkg::YEAR_W'(r_c[6].mp >= 4'd10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < CV_STG; s++) begin
                if (adv[s]) begin
                    r_v[s] <= v_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < CV_STG; s++) begin
            if (adv[s]) begin
                r_c[s] <= n_c[s];
            end
        end
    end

    assign o_rdy   = adv[0];
    assign o_vld   = r_v[CV_STG-1];
    assign o_year  = r_c[CV_STG-1].year;
    assign o_month = r_c[CV_STG-1].month;
    assign o_day   = r_c[CV_STG-1].day;
    assign o_hms   = r_c[CV_STG-1].hms;

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch-seconds to calendar converter: mode register and the
// three pipeline sections. Depends on e2c_pkg, e2c_msdiv, e2c_split, e2c_civil.
//
//   channel   direction  handshake                   word
//   in        input      i_in_valid / o_in_stall     i_rtc_seconds, i_uptime_ms
//   out       output     o_out_valid / i_out_stall   o_year .. o_second
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (clock_present)
//
// One word per cycle sustained while the output is not stalled. The millisecond
// divider has a multiply and a remainder stage per 16-bit uptime digit plus the
// select, and is followed by the seconds split and the date section.
// Each stage advances when empty or when the stage after it advances, so
// bubbles fill while the output word is held; o_in_stall rises only with a
// full pipeline and a stalled output. Reset clears all valid bits and the mode.

module epoch_seconds_to_calendar (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [e2c_pkg::SECS_W-1:0]   i_rtc_seconds,
    input  logic [e2c_pkg::UPTIME_W-1:0] i_uptime_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [e2c_pkg::YEAR_W-1:0]   o_year,
    output logic [e2c_pkg::MONTH_W-1:0]  o_month,
    output logic [e2c_pkg::DAY_W-1:0]    o_day,
    output logic [e2c_pkg::HOUR_W-1:0]   o_hour,
    output logic [e2c_pkg::MIN_W-1:0]    o_minute,
    output logic [e2c_pkg::SEC_W-1:0]    o_second,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    logic                       r_clock_present;
    logic                       ms_rdy;
    logic                       ms_vld;
    logic [e2c_pkg::SECS_W-1:0]  ms_secs;
    logic                       sp_rdy;
    logic                       sp_vld;
    logic [e2c_pkg::DAYS_W-1:0]  sp_days;
    e2c_pkg::t_hms              sp_hms;
    logic                       cv_rdy;
    e2c_pkg::t_hms              cv_hms;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_present <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clock_present <= i_cfg_data;
        end
    end

    e2c_msdiv u_msdiv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clock_present (r_clock_present),
        .i_vld           (i_in_valid),
        .i_rtc_seconds   (i_rtc_seconds),
        .i_uptime_ms     (i_uptime_ms),
        .o_rdy           (ms_rdy),
        .i_nxt_rdy       (sp_rdy),
        .o_vld           (ms_vld),
        .o_secs          (ms_secs)
    );

    e2c_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (ms_vld),
        .i_secs    (ms_secs),
        .o_rdy     (sp_rdy),
        .i_nxt_rdy (cv_rdy),
        .o_vld     (sp_vld),
        .o_days    (sp_days),
        .o_hms     (sp_hms)
    );

    e2c_civil u_civil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (sp_vld),
        .i_days    (sp_days),
        .i_hms     (sp_hms),
        .o_rdy     (cv_rdy),
        .i_nxt_rdy (!i_out_stall),
        .o_vld     (o_out_valid),
        .o_year    (o_year),
        .o_month   (o_month),
        .o_day     (o_day),
        .o_hms     (cv_hms)
    );

    assign o_in_stall = !ms_rdy;
    assign o_hour     = cv_hms.hour;
    assign o_minute   = cv_hms.minute;
    assign o_second   = cv_hms.second;

    // back-pressure at the input only comes from a held output word
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    // a word leaving the pipeline carries a well-formed date and time
    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1
                         && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("calendar field out of range");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_year >= 12'd1970 && o_year <= 12'd2106))
        else $error("year out of range");

endmodule
